// ===== hw/rtl/ecta_pkg.sv =====
// shared types, constants and corner tables for the element clip and altitude setup
// no dependencies; every other file of the block imports this package
package ecta_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int VW      = 48;   // packed vertex word
  localparam int MODE_W  = 2;
  localparam int CELL_W  = 29;
  localparam int GROUP_W = 16;
  localparam int EDGE_W  = 32;
  localparam int ALT_W   = 16;
  localparam int QW      = 32;   // quotient width ahead of the square root
  localparam int IDX_W   = 2;

  localparam int DIV_STAGES  = QW;
  localparam int SQRT_STAGES = QW / 2;
  localparam int ALT_LAT     = 1 + DIV_STAGES + SQRT_STAGES;

  localparam logic [MODE_W-1:0] MODE_TRI  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TET  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;   // unused code, element dropped

  localparam logic [IDX_W-1:0] REG_POINT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_NORMAL = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLIP   = 2'd2;
  localparam logic [IDX_W-1:0] REG_GROUP  = 2'd3;

  localparam logic [2:0] EDGE_NONE  = 3'd0;
  localparam logic [2:0] EDGE_ALL   = 3'd7;
  localparam logic [2:0] EDGE_QUAD0 = 3'd5;
  localparam logic [2:0] EDGE_QUAD1 = 3'd3;

  typedef struct packed {
    logic [VW-1:0]      point;
    logic [VW-1:0]      normal;
    logic               clip;
    logic [GROUP_W-1:0] group;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CELL_W-1:0]   cell_idx;
    logic [3:0][VW-1:0]  v;
  } elem_t;

  typedef struct packed {
    logic [VW-1:0]     c0;
    logic [VW-1:0]     c1;
    logic [VW-1:0]     c2;
    logic [EDGE_W-1:0] ecw;
    logic              last;
  } tri_side_t;

  function automatic logic [2:0] tri_count(input logic [MODE_W-1:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_QUAD: n = 3'd2;
      MODE_TET:  n = 3'd4;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  // vertex index of corner k of triangle j
  function automatic logic [1:0] tri_corner(input logic [MODE_W-1:0] mode,
                                            input logic [1:0] j, input logic [1:0] k);
    logic [5:0] row;
    unique case ({mode, j})
      {MODE_TRI, 2'd0}:  row = {2'd2, 2'd1, 2'd0};
      {MODE_QUAD, 2'd0}: row = {2'd2, 2'd1, 2'd0};
      {MODE_QUAD, 2'd1}: row = {2'd3, 2'd2, 2'd0};
      {MODE_TET, 2'd0}:  row = {2'd1, 2'd3, 2'd2};
      {MODE_TET, 2'd1}:  row = {2'd2, 2'd3, 2'd0};
      {MODE_TET, 2'd2}:  row = {2'd0, 2'd3, 2'd1};
      {MODE_TET, 2'd3}:  row = {2'd1, 2'd2, 2'd0};
      default:           row = 6'd0;
    endcase
    return row[k*2 +: 2];
  endfunction

  function automatic logic [2:0] tri_edges(input logic [MODE_W-1:0] mode,
                                           input logic [1:0] j);
    logic [2:0] e;
    unique case ({mode, j})
      {MODE_TRI, 2'd0}:  e = EDGE_ALL;
      {MODE_QUAD, 2'd0}: e = EDGE_QUAD0;
      {MODE_QUAD, 2'd1}: e = EDGE_QUAD1;
      {MODE_TET, 2'd0},
      {MODE_TET, 2'd1},
      {MODE_TET, 2'd2},
      {MODE_TET, 2'd3}:  e = EDGE_ALL;
      default:           e = EDGE_NONE;
    endcase
    return e;
  endfunction

endpackage

// ===== hw/rtl/element_clip_triangle_altitude_setup.sv =====
// top level of the element clip and triangle altitude setup block
// depends on ecta_pkg, ecta_clip, ecta_split, ecta_heron, ecta_alt
//
// Takes one mesh element per request (triangle, quad or tetrahedron), drops
// it if its group differs from selected_group, if its mode code is unused or
// if the clip plane test rejects it (with clipping off, every tetrahedron),
// and otherwise emits one result per triangle: corners, edge flags with the
// cell index in bits [31:3], and three heron altitudes in unsigned Q16.0,
// saturating at 0xFFFF. One triangle leaves per clock while the output is
// not stalled; the splitter issues the triangles of one element in turn, one
// for a triangle element, two for a quad and four for a tetrahedron. A request
// passes 61 register stages: 3 clip stages, the splitter, 7 heron stages, 49
// divide and root stages (one quotient bit then one root bit per stage) and
// the output register. The first stage loads at the accepting edge. A stalled
// output freezes the whole triangle pipeline; the input side keeps accepting
// until the clip stages and the splitter fill.
module element_clip_triangle_altitude_setup #(
  parameter int COORD_WIDTH = ecta_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // mode, cell_index, group_id, vertex_a, vertex_b, vertex_c, vertex_d
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [239:0] in_tdata,
  // corner_a, corner_b, corner_c, altitude_a, altitude_b, altitude_c,
  // edge_cell_word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [223:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);
  import ecta_pkg::*;

  localparam int E2W = 2 * COORD_WIDTH + 2;
  localparam int HW  = 2 * E2W + 3;

  cfg_t      cfg_r;
  elem_t     in_el;
  logic      ce;
  logic      cl_valid, cl_take;
  elem_t     cl_el;
  logic      sp_valid;
  tri_side_t sp_side;
  logic      hr_valid;
  tri_side_t hr_side;
  logic [HW-1:0]  hr_h;
  logic [E2W-1:0] hr_e2 [3];
  logic [ALT_W-1:0] alt [3];
  logic      sd_v_r [ALT_LAT];
  tri_side_t sd_r   [ALT_LAT];
  logic      out_tvalid_r, out_tlast_r;
  logic [223:0] out_tdata_r;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT:  cfg_r.point  <= cfg_wdata;
        REG_NORMAL: cfg_r.normal <= cfg_wdata;
        REG_CLIP:   cfg_r.clip   <= cfg_wdata[0];
        REG_GROUP:  cfg_r.group  <= cfg_wdata[GROUP_W-1:0];
      endcase
    end
  end

  assign in_el.mode     = in_tdata[1:0];
  assign in_el.cell_idx = in_tdata[30:2];
  assign in_el.v[0]     = in_tdata[94:47];
  assign in_el.v[1]     = in_tdata[142:95];
  assign in_el.v[2]     = in_tdata[190:143];
  assign in_el.v[3]     = in_tdata[238:191];

  // whole triangle pipeline moves when the output register can take a result
  assign ce = !out_tvalid_r || out_tready;

  ecta_clip #(.W(COORD_WIDTH)) u_clip (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_el,
    .in_group(in_tdata[46:31]),
    .out_valid(cl_valid), .out_el(cl_el), .out_take(cl_take)
  );

  ecta_split u_split (
    .clk, .rst_n, .el_valid(cl_valid), .el(cl_el), .el_take(cl_take),
    .adv(ce), .tri_valid(sp_valid), .tri_side(sp_side)
  );

  ecta_heron #(.W(COORD_WIDTH), .E2W(E2W), .HW(HW)) u_heron (
    .clk, .rst_n, .adv(ce), .in_valid(sp_valid), .in_side(sp_side),
    .out_valid(hr_valid), .out_side(hr_side), .out_h(hr_h), .out_e2(hr_e2)
  );

  for (genvar g = 0; g < 3; g++) begin : g_alt
    ecta_alt #(.E2W(E2W), .HW(HW)) u_alt (
      .clk, .adv(ce), .h(hr_h), .e2(hr_e2[g]), .alt(alt[g])
    );
  end

  // corners, edge word and last ride alongside the altitude lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ALT_LAT; s++) sd_v_r[s] <= 1'b0;
    end else if (ce) begin
      sd_v_r[0] <= hr_valid;
      for (int s = 1; s < ALT_LAT; s++) sd_v_r[s] <= sd_v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd_r[0] <= hr_side;
      for (int s = 1; s < ALT_LAT; s++) sd_r[s] <= sd_r[s-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      out_tvalid_r <= sd_v_r[ALT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= {sd_r[ALT_LAT-1].ecw, alt[2], alt[1], alt[0],
                      sd_r[ALT_LAT-1].c2, sd_r[ALT_LAT-1].c1, sd_r[ALT_LAT-1].c0};
      out_tlast_r <= sd_r[ALT_LAT-1].last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== hw/rtl/ecta_clip.sv =====
// group filter and clip plane test, three register stages
// depends on ecta_pkg
module ecta_clip #(
  parameter int W = ecta_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ecta_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ecta_pkg::elem_t             in_el,
  input  logic [ecta_pkg::GROUP_W-1:0] in_group,
  output logic                        out_valid,
  output ecta_pkg::elem_t             out_el,
  input  logic                        out_take
);
  import ecta_pkg::*;

  localparam int PW   = (3 * W > VW) ? 3 * W : VW;
  localparam int PRW  = 2 * W + 1;
  localparam int DOTW = 2 * W + 3;

  function automatic logic signed [W-1:0] coord(input logic [VW-1:0] word, input int d);
    logic [PW-1:0] pad;
    pad = PW'(word);
    return pad[d*W +: W];
  endfunction

  logic v1_r, v2_r, v3_r;
  logic ok1_r, ok2_r, ok3_r;
  elem_t el1_r, el2_r, el3_r;
  logic signed [W:0]      d_r   [4][3];
  logic signed [W-1:0]    n_r   [3];
  logic signed [PRW-1:0]  p_r   [4][3];
  logic signed [DOTW-1:0] dot_r [4];
  logic [3:0] pos;
  logic all_pos, none_pos, is_tri, is_tet, keep, adv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pos[i] = !dot_r[i][DOTW-1] && (dot_r[i] != '0);
    end
    is_tri   = (el3_r.mode == MODE_TRI);
    is_tet   = (el3_r.mode == MODE_TET);
    all_pos  = pos[0] && pos[1] && pos[2] && (is_tri || pos[3]);
    none_pos = !pos[0] && !pos[1] && !pos[2] && (is_tri || !pos[3]);
    if (cfg.clip) begin
      keep = ok3_r && (is_tet ? !(all_pos || none_pos) : !none_pos);
    end else begin
      keep = ok3_r && !is_tet;
    end
  end

  assign out_valid = v3_r && keep;
  assign out_el    = el3_r;
  assign adv       = !out_valid || out_take;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: offsets from the plane point
      el1_r <= in_el;
      ok1_r <= (in_group == cfg.group) && (in_el.mode != MODE_NONE);
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          d_r[i][k] <= (W+1)'(coord(in_el.v[i], k)) - (W+1)'(coord(cfg.point, k));
        end
      end
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= coord(cfg.normal, k);
      end
      // stage 2: products with the normal
      el2_r <= el1_r;
      ok2_r <= ok1_r;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          p_r[i][k] <= d_r[i][k] * n_r[k];
        end
      end
      // stage 3: dot products
      el3_r <= el2_r;
      ok3_r <= ok2_r;
      for (int i = 0; i < 4; i++) begin
        dot_r[i] <= DOTW'(p_r[i][0]) + DOTW'(p_r[i][1]) + DOTW'(p_r[i][2]);
      end
    end
  end

endmodule

// ===== hw/rtl/ecta_split.sv =====
// holds one kept element and issues its triangles one per cycle while the pipeline advances
// depends on ecta_pkg
module ecta_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 el_valid,
  input  ecta_pkg::elem_t      el,
  output logic                 el_take,
  input  logic                 adv,
  output logic                 tri_valid,
  output ecta_pkg::tri_side_t  tri_side
);
  import ecta_pkg::*;

  logic       hold_r;
  elem_t      el_r;
  logic [1:0] j_r;
  logic       is_last;

  assign is_last   = ({1'b0, j_r} == (tri_count(el_r.mode) - 3'd1));
  assign el_take   = el_valid && (!hold_r || (adv && is_last));
  assign tri_valid = hold_r;

  always_comb begin
    tri_side.c0   = el_r.v[tri_corner(el_r.mode, j_r, 2'd0)];
    tri_side.c1   = el_r.v[tri_corner(el_r.mode, j_r, 2'd1)];
    tri_side.c2   = el_r.v[tri_corner(el_r.mode, j_r, 2'd2)];
    tri_side.ecw  = {el_r.cell_idx, tri_edges(el_r.mode, j_r)};
    tri_side.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      j_r    <= 2'd0;
    end else if (el_take) begin
      hold_r <= 1'b1;
      j_r    <= 2'd0;
    end else if (adv && hold_r) begin
      hold_r <= !is_last;
      j_r    <= j_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (el_take) begin
      el_r <= el;
    end
  end

endmodule

// ===== hw/rtl/ecta_heron.sv =====
// squared edge lengths and the heron term, seven register stages
// depends on ecta_pkg
module ecta_heron #(
  parameter int W   = ecta_pkg::COORD_WIDTH_DEF,
  parameter int E2W = 2 * W + 2,
  parameter int HW  = 4 * W + 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  ecta_pkg::tri_side_t in_side,
  output logic                out_valid,
  output ecta_pkg::tri_side_t out_side,
  output logic [HW-1:0]       out_h,
  output logic [E2W-1:0]      out_e2 [3]
);
  import ecta_pkg::*;

  localparam int NS  = 7;
  localparam int PW  = (3 * W > VW) ? 3 * W : VW;
  localparam int LW  = (E2W + 1) / 2;
  localparam int HIW = E2W - LW;
  localparam int PPW = 2 * E2W;

  function automatic logic signed [W-1:0] coord(input logic [VW-1:0] word, input int d);
    logic [PW-1:0] pad;
    pad = PW'(word);
    return pad[d*W +: W];
  endfunction

  logic      v_r    [NS];
  tri_side_t side_r [NS];
  logic [W-1:0]     mag_r  [3][3];
  logic [2*W-1:0]   sq_r   [3][3];
  logic [E2W-1:0]   e2_r   [5][3];
  logic [2*LW-1:0]  pp_r   [6][4];
  logic [PPW-1:0]   prod_r [6];
  logic [HW-1:0]    pos_r, neg_r, h_r;
  logic [VW-1:0]    pt     [3];

  assign pt[0] = in_side.c0;
  assign pt[1] = in_side.c1;
  assign pt[2] = in_side.c2;

  assign out_valid = v_r[NS-1];
  assign out_side  = side_r[NS-1];
  assign out_h     = h_r;
  assign out_e2    = e2_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W:0] d;
    logic [W:0] dm;
    logic [LW-1:0] xl, yl;
    logic [HIW-1:0] xh, yh;
    int xi, yi;
    if (adv) begin
      side_r[0] <= in_side;
      for (int s = 1; s < NS; s++) side_r[s] <= side_r[s-1];
      // edge a from corner 2 to 1, b from 0 to 2, c from 1 to 0
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          d = (W+1)'(coord(pt[(e+2)%3], k)) - (W+1)'(coord(pt[(e+1)%3], k));
          dm = d[W] ? -d : d;
          mag_r[e][k] <= dm[W-1:0];
          sq_r[e][k]  <= (2*W)'(mag_r[e][k]) * (2*W)'(mag_r[e][k]);
        end
        e2_r[0][e] <= E2W'(sq_r[e][0]) + E2W'(sq_r[e][1]) + E2W'(sq_r[e][2]);
      end
      // squared lengths ride along until the heron term is ready
      for (int s = 1; s < 5; s++) e2_r[s] <= e2_r[s-1];
      // split products: ab, bc, ca, aa, bb, cc
      for (int pr = 0; pr < 6; pr++) begin
        xi = (pr < 3) ? pr : pr - 3;
        yi = (pr < 3) ? (pr + 1) % 3 : pr - 3;
        xl = e2_r[0][xi][LW-1:0];
        xh = e2_r[0][xi][E2W-1:LW];
        yl = e2_r[0][yi][LW-1:0];
        yh = e2_r[0][yi][E2W-1:LW];
        pp_r[pr][0] <= (2*LW)'(xl) * (2*LW)'(yl);
        pp_r[pr][1] <= (2*LW)'(xl) * (2*LW)'(yh);
        pp_r[pr][2] <= (2*LW)'(xh) * (2*LW)'(yl);
        pp_r[pr][3] <= (2*LW)'(xh) * (2*LW)'(yh);
        prod_r[pr]  <= PPW'(pp_r[pr][0])
                     + ((PPW'(pp_r[pr][1]) + PPW'(pp_r[pr][2])) << LW)
                     + (PPW'(pp_r[pr][3]) << (2 * LW));
      end
      pos_r <= (HW'(prod_r[0]) + HW'(prod_r[1]) + HW'(prod_r[2])) << 1;
      neg_r <= HW'(prod_r[3]) + HW'(prod_r[4]) + HW'(prod_r[5]);
      // negative heron term clamps to zero
      h_r   <= (pos_r > neg_r) ? pos_r - neg_r : '0;
    end
  end

endmodule

// ===== hw/rtl/ecta_alt.sv =====
// one altitude lane: restoring divide by 4*e2 then integer square root
// depends on ecta_pkg; one quotient bit and one root bit per stage
module ecta_alt #(
  parameter int E2W = 2 * ecta_pkg::COORD_WIDTH_DEF + 2,
  parameter int HW  = 4 * ecta_pkg::COORD_WIDTH_DEF + 7
) (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [HW-1:0]              h,
  input  logic [E2W-1:0]             e2,
  output logic [ecta_pkg::ALT_W-1:0] alt
);
  import ecta_pkg::*;

  localparam int DEW = E2W + 2;
  localparam int DW  = DEW + QW;
  localparam int CW  = (HW > DW) ? HW : DW;

  logic [DW-1:0]  rem_r [DIV_STAGES+1];
  logic [DEW-1:0] den_r [DIV_STAGES+1];
  logic [QW-1:0]  q_r   [DIV_STAGES+1];
  logic           sat_r [ALT_LAT];
  logic [QW-1:0]  x_r   [SQRT_STAGES];
  logic [QW-1:0]  res_r [SQRT_STAGES];

  assign alt = sat_r[ALT_LAT-1] ? '1 : res_r[SQRT_STAGES-1][ALT_W-1:0];

  always_ff @(posedge clk) begin
    logic [DEW-1:0] den;
    logic [DW-1:0]  t;
    logic [QW-1:0]  xin, rin, bitv;
    logic [QW:0]    trial;
    if (adv) begin
      den = {e2, 2'b00};
      den_r[0] <= den;
      rem_r[0] <= DW'(h);
      q_r[0]   <= '0;
      sat_r[0] <= (e2 == '0) || (CW'(h) >= (CW'(den) << QW));
      for (int s = 1; s < ALT_LAT; s++) sat_r[s] <= sat_r[s-1];
      for (int s = 1; s <= DIV_STAGES; s++) begin
        t = DW'(den_r[s-1]) << (QW - s);
        den_r[s] <= den_r[s-1];
        if (rem_r[s-1] >= t) begin
          rem_r[s] <= rem_r[s-1] - t;
          q_r[s]   <= q_r[s-1] | (QW'(1) << (QW - s));
        end else begin
          rem_r[s] <= rem_r[s-1];
          q_r[s]   <= q_r[s-1];
        end
      end
      for (int k = 0; k < SQRT_STAGES; k++) begin
        xin   = (k == 0) ? q_r[DIV_STAGES] : x_r[k-1];
        rin   = (k == 0) ? '0 : res_r[k-1];
        bitv  = QW'(1) << (QW - 2 - 2 * k);
        trial = (QW+1)'(rin) + (QW+1)'(bitv);
        if ((QW+1)'(xin) >= trial) begin
          x_r[k]   <= xin - trial[QW-1:0];
          res_r[k] <= (rin >> 1) + bitv;
        end else begin
          x_r[k]   <= xin;
          res_r[k] <= rin >> 1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ecta_checker.sv =====
// port-level checks on the result channel of the element clip and altitude setup
// depends on ecta_pkg; bound to the top level below
module ecta_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata,
  input logic         out_tlast
);
  import ecta_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result request right after reset");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[194:192] == EDGE_ALL || out_tdata[194:192] == EDGE_QUAD0
                || out_tdata[194:192] == EDGE_QUAD1)
    else $error("bad edge flags");

  a_quad0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[194:192] == EDGE_QUAD0 |-> !out_tlast)
    else $error("first quad triangle marked last");

  a_quad1: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[194:192] == EDGE_QUAD1 |-> out_tlast)
    else $error("second quad triangle not marked last");

endmodule

bind element_clip_triangle_altitude_setup ecta_checker u_checker (.*);

// ===== bench/element_clip_triangle_altitude_setup_tb.sv =====
// testbench for the element clip and triangle altitude setup block
// depends on ecta_pkg and element_clip_triangle_altitude_setup; predicts each
// triangle result (corners, edge word, heron altitudes) and checks it in order
`timescale 1ns / 100ps

module element_clip_triangle_altitude_setup_tb;
  import ecta_pkg::*;

  localparam int W = 16;
  localparam int LIMIT = 400000;
  localparam int TAIL = 200;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [47:0] ca;
    logic [47:0] cb;
    logic [47:0] cc;
    logic [15:0] alt_a;
    logic [15:0] alt_b;
    logic [15:0] alt_c;
    logic [31:0] ecw;
    logic        last;
  } tri_res_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [28:0] cell_idx;
    logic [15:0] grp;
    logic [3:0][47:0] v;
  } elem_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [239:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_POINT;
  logic [47:0] cfg_wdata = '0;

  element_clip_triangle_altitude_setup dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the block's registers
  logic [47:0] m_point, m_normal;
  logic        m_clip;
  logic [15:0] m_group;

  elem_req_t pending_reqs[$];
  tri_res_t  expected_tris[$];
  elem_req_t cur_req;

  int n_err = 0;
  int n_tris = 0;
  int n_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cnt = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  bit in_fire = 1'b0;

  // signed coordinate d of a packed vertex
  function automatic longint coord_of(logic [47:0] w, int d);
    logic signed [W-1:0] c;
    c = w[d*W +: W];
    return longint'(c);
  endfunction

  function automatic logic [127:0] edge_sq(logic [47:0] p, logic [47:0] q);
    logic [127:0] s;
    longint e;
    s = '0;
    for (int d = 0; d < 3; d++) begin
      e = coord_of(p, d) - coord_of(q, d);
      s += 128'(e * e);
    end
    return s;
  endfunction

  // floor(sqrt(floor(h / 4e2))) with saturation
  function automatic logic [15:0] heron_alt(logic [127:0] h, logic [127:0] e2);
    logic [127:0] q, r;
    if (e2 == 0) return 16'hFFFF;
    q = h / (e2 << 2);
    if (q >= 128'h1_0000_0000) return 16'hFFFF;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= q) r |= 128'd1 << b;
    end
    return r[15:0];
  endfunction

  // vertex indices per triangle, {corner a, b, c}
  function automatic void corners_of(logic [1:0] mode, int j, output int k[3]);
    if (mode == MODE_TRI || (mode == MODE_QUAD && j == 0)) begin
      k = '{0, 1, 2};
    end else if (mode == MODE_QUAD) begin
      k = '{0, 2, 3};
    end else begin
      case (j)
        0: k = '{2, 3, 1};
        1: k = '{0, 3, 2};
        2: k = '{1, 3, 0};
        default: k = '{0, 2, 1};
      endcase
    end
  endfunction

  // work out the triangles that one accepted element causes
  task automatic predict_triangles(elem_req_t e);
    int nv, side, count;
    int k[3];
    longint dot;
    logic [127:0] a2, b2, c2, pos, neg, h;
    logic [2:0] flags;
    tri_res_t t;
    if (e.grp != m_group || e.mode > MODE_TET) return;
    nv = (e.mode == MODE_TRI) ? 3 : 4;
    if (m_clip) begin
      side = 0;
      for (int i = 0; i < nv; i++) begin
        dot = 0;
        for (int d = 0; d < 3; d++)
          dot += (coord_of(e.v[i], d) - coord_of(m_point, d)) * coord_of(m_normal, d);
        side += (dot > 0) ? 1 : -1;
      end
      // volume elements wholly on one side, surfaces wholly below, are dropped
      if (e.mode == MODE_TET && (side == nv || side == -nv)) return;
      if (e.mode != MODE_TET && side == -nv) return;
    end else if (e.mode == MODE_TET) begin
      return;
    end
    count = (e.mode == MODE_TRI) ? 1 : (e.mode == MODE_QUAD) ? 2 : 4;
    for (int j = 0; j < count; j++) begin
      corners_of(e.mode, j, k);
      t.ca = e.v[k[0]];
      t.cb = e.v[k[1]];
      t.cc = e.v[k[2]];
      a2 = edge_sq(t.cc, t.cb);
      b2 = edge_sq(t.ca, t.cc);
      c2 = edge_sq(t.cb, t.ca);
      pos = 2 * (a2 * b2 + b2 * c2 + c2 * a2);
      neg = a2 * a2 + b2 * b2 + c2 * c2;
      // negative heron term clamps to zero
      h = (pos > neg) ? pos - neg : 0;
      t.alt_a = heron_alt(h, a2);
      t.alt_b = heron_alt(h, b2);
      t.alt_c = heron_alt(h, c2);
      if (e.mode == MODE_QUAD) flags = (j == 0) ? EDGE_QUAD0 : EDGE_QUAD1;
      else flags = EDGE_ALL;
      t.ecw = {e.cell_idx, flags};
      t.last = (j == count - 1);
      expected_tris = {expected_tris, t};
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on triangle %0d: %s got %h expected %h", n_tris, what, got, want);
    n_err++;
  endtask

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  // driver: offers queued requests, idles at random
  always @(negedge clk) begin
    logic vld_nxt;
    if (rst_n) begin
      vld_nxt = in_tvalid;
      if (in_fire) begin
        predict_triangles(cur_req);
        n_sent++;
        vld_nxt = 1'b0;
      end
      if (!vld_nxt && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        // fields from the low bits: mode, cell, group, vertex a..d
        in_tdata <= {1'b0, cur_req.v[3], cur_req.v[2], cur_req.v[1], cur_req.v[0],
                     cur_req.grp, cur_req.cell_idx, cur_req.mode};
        vld_nxt = 1'b1;
      end
      in_tvalid <= vld_nxt;
    end
  end

  // receiver readiness: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor: check each accepted triangle against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      tri_res_t want;
      if (expected_tris.size() == 0) begin
        report_mismatch("unexpected triangle", out_tdata[63:0], 64'd0);
      end else begin
        want = expected_tris.pop_front();
        if (out_tdata[47:0] !== want.ca)
          report_mismatch("corner_a", 64'(out_tdata[47:0]), 64'(want.ca));
        if (out_tdata[95:48] !== want.cb)
          report_mismatch("corner_b", 64'(out_tdata[95:48]), 64'(want.cb));
        if (out_tdata[143:96] !== want.cc)
          report_mismatch("corner_c", 64'(out_tdata[143:96]), 64'(want.cc));
        if (out_tdata[159:144] !== want.alt_a)
          report_mismatch("altitude_a", 64'(out_tdata[159:144]), 64'(want.alt_a));
        if (out_tdata[175:160] !== want.alt_b)
          report_mismatch("altitude_b", 64'(out_tdata[175:160]), 64'(want.alt_b));
        if (out_tdata[191:176] !== want.alt_c)
          report_mismatch("altitude_c", 64'(out_tdata[191:176]), 64'(want.alt_c));
        if (out_tdata[223:192] !== want.ecw)
          report_mismatch("edge_cell_word", 64'(out_tdata[223:192]), 64'(want.ecw));
        if (out_tlast !== want.last)
          report_mismatch("last", 64'(out_tlast), 64'(want.last));
      end
      n_tris++;
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POINT: m_point = val;
      REG_NORMAL: m_normal = val;
      REG_CLIP: m_clip = val[0];
      default: m_group = val[15:0];
    endcase
  endtask

  function automatic logic [47:0] pack_vtx(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // small vertex near the origin so altitudes stay in range most of the time
  function automatic logic [47:0] near_vtx();
    return pack_vtx($urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                    $urandom_range(16384) - 8192);
  endfunction

  function automatic elem_req_t rand_elem(logic [15:0] grp);
    elem_req_t e;
    e.mode = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
    e.cell_idx = 29'($urandom);
    e.grp = ($urandom_range(9) == 0) ? 16'($urandom) : grp;
    for (int i = 0; i < 4; i++)
      e.v[i] = ($urandom_range(4) == 0) ? 48'({$urandom, $urandom}) : near_vtx();
    return e;
  endfunction

  task automatic drain(int wait_cycles);
    int n;
    n = 0;
    wait (pending_reqs.size() == 0 && !in_tvalid);
    while (expected_tris.size() > 0) @(posedge clk);
    while (n < wait_cycles) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic queue_random(int count, logic [15:0] grp);
    for (int i = 0; i < count; i++) pending_reqs = {pending_reqs, rand_elem(grp)};
  endtask

  initial begin
    elem_req_t e;
    m_point = '0; m_normal = '0; m_clip = 1'b0; m_group = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: clipping off, group 0
    send_idle_pct = 16; recv_idle_pct = 64;
    e.grp = 16'h0; e.cell_idx = '1;
    e.mode = MODE_TRI;
    e.v[0] = pack_vtx(0, 0, 0); e.v[1] = pack_vtx(16384, 0, 0);
    e.v[2] = pack_vtx(0, 16384, 0); e.v[3] = '1;
    pending_reqs = {pending_reqs, e};
    // extremes of the coordinates, altitude saturation
    e.cell_idx = '0;
    e.v[0] = pack_vtx(-32768, -32768, -32768); e.v[1] = pack_vtx(32767, 32767, 32767);
    e.v[2] = pack_vtx(32767, -32768, 0);
    pending_reqs = {pending_reqs, e};
    // zero-length edge and degenerate triangle
    e.v[1] = e.v[0];
    pending_reqs = {pending_reqs, e};
    e.v[0] = '0; e.v[1] = '0; e.v[2] = '0;
    pending_reqs = {pending_reqs, e};
    // quad, tetrahedron (dropped without clipping), unused mode, other group
    e.mode = MODE_QUAD; e.cell_idx = 29'h1555_5555;
    e.v[0] = pack_vtx(0, 0, 0); e.v[1] = pack_vtx(4096, 0, 0);
    e.v[2] = pack_vtx(4096, 4096, 0); e.v[3] = pack_vtx(0, 4096, 0);
    pending_reqs = {pending_reqs, e};
    e.mode = MODE_TET; pending_reqs = {pending_reqs, e};
    e.mode = MODE_NONE; pending_reqs = {pending_reqs, e};
    e.mode = MODE_TRI; e.grp = 16'hFFFF; pending_reqs = {pending_reqs, e};
    queue_random(60, 16'h0);
    drain(TAIL);

    // clip plane z = 0, normal +z, group at the top of its range
    write_reg(REG_POINT, '0);
    write_reg(REG_NORMAL, pack_vtx(0, 0, 16384));
    write_reg(REG_CLIP, 48'd1);
    write_reg(REG_GROUP, 48'hFFFF);
    send_idle_pct = 64; recv_idle_pct = 16;
    e.grp = 16'hFFFF; e.mode = MODE_TET;
    e.v[0] = pack_vtx(0, 0, -4096); e.v[1] = pack_vtx(4096, 0, 4096);
    e.v[2] = pack_vtx(0, 4096, 4096); e.v[3] = pack_vtx(0, 0, 8192);
    pending_reqs = {pending_reqs, e};       // straddles the plane
    e.v[0] = pack_vtx(0, 0, 4096); pending_reqs = {pending_reqs, e};   // all above
    e.mode = MODE_TRI; e.v[0] = pack_vtx(0, 0, 0);
    e.v[1] = pack_vtx(1, 0, 0); e.v[2] = pack_vtx(0, 1, 0);
    pending_reqs = {pending_reqs, e};       // on the plane counts as below
    e.mode = MODE_QUAD; e.v[3] = pack_vtx(0, 0, 1); pending_reqs = {pending_reqs, e};
    queue_random(70, 16'hFFFF);
    drain(TAIL);

    // random plane, mixed group, no idling; long receiver hold-off first
    write_reg(REG_POINT, 48'({$urandom, $urandom}));
    write_reg(REG_NORMAL, 48'({$urandom, $urandom}));
    write_reg(REG_GROUP, 48'h5A5A);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_go = 1'b1;
    queue_random(70, 16'h5A5A);
    drain(TAIL);
    write_reg(REG_CLIP, 48'd0);
    write_reg(REG_POINT, 48'hFFFF_FFFF_FFFF);
    queue_random(20, 16'h5A5A);
    drain(TAIL);

    $display("sent %0d elements over four register settings, checked %0d triangles",
             n_sent, n_tris);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ecta_pkg.sv
hw/rtl/ecta_clip.sv
hw/rtl/ecta_split.sv
hw/rtl/ecta_heron.sv
hw/rtl/ecta_alt.sv
hw/rtl/element_clip_triangle_altitude_setup.sv
hw/rtl/ecta_checker.sv
bench/element_clip_triangle_altitude_setup_tb.sv
